FILE: hw/rtl/prsd_pkg.sv
// Package: shared types and constants for the palette RLE sprite decoder.
`default_nettype none

package prsd_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

   localparam logic       OP_PALETTE_WRITE = 1'b0;
   localparam logic       OP_FRAME_DATA    = 1'b1;
   localparam logic [7:0] CTRL_RUN_BASE    = 8'h80;
   localparam logic [7:0] TRANSPARENT_LEVEL = 8'hFF;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       frame_start;
      logic [7:0] entry_index;
      logic [7:0] entry_red;
      logic [7:0] entry_green;
      logic [7:0] entry_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic [6:0] repeat_count;
      logic       is_transparent;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] index;
      logic [23:0] rgb;
   } pal_wr_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] index;
   } pal_rd_type;

endpackage

`default_nettype wire

FILE: hw/rtl/prsd_palette.sv
// Palette color memory with registered read and out-of-range masking.
`default_nettype none

module prsd_palette
   import prsd_pkg::*;
(
   input  wire logic        clock,
   input  wire pal_wr_type  wr,
   input  wire pal_rd_type  rd,
   output logic [23:0]      rd_rgb
);

   logic [23:0] mem [PALETTE_DEPTH];
   logic [23:0] rd_data_ff;
   logic        rd_oor_ff;
   logic        wr_in_range;
   logic        rd_in_range;

   assign wr_in_range = ({1'b0, wr.index} < PAL_LIMIT);
   assign rd_in_range = ({1'b0, rd.index} < PAL_LIMIT);

   always_ff @(posedge clock) begin
      if (wr.valid && wr_in_range) begin
         mem[wr.index[PAL_ADDR_W-1:0]] <= wr.rgb;
      end
   end

   // read data held until the next read, so a stalled word keeps its color
   always_ff @(posedge clock) begin
      if (rd.valid) begin
         rd_data_ff <= mem[rd.index[PAL_ADDR_W-1:0]];
         rd_oor_ff  <= !rd_in_range;
      end
   end

   assign rd_rgb = rd_oor_ff ? 24'h000000 : rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/palette_rle_sprite_decoder_core.sv
// Top level: palette-indexed run-length sprite decoder, one byte per cycle while rsp is not stalled.
//
//  channel | ports                            | moves
//  --------+----------------------------------+-----------------------------------
//  req     | req_valid, req_ready, req_data   | palette write or frame data byte
//  rsp     | rsp_valid, rsp_ready, rsp_data   | pixel color, repeat count, flag
//
// Takes one word per cycle unless rsp back-pressure fills the pipeline; a pixel
// reaches rsp through the palette read register and then the result register.
// Reset clears the literal byte counter and both valid flags; palette colors
// stay undefined until written.
// req_ready drops only while the decode stage and result register both hold
// a word and rsp_ready is low.
`default_nettype none

module palette_rle_sprite_decoder_core
   import prsd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // literal bytes still expected in the current frame
   logic [7:0] lit_rem_ff, lit_rem_in;

   // decode stage: waits for the palette read
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_trans_ff, s1_trans_in;
   logic [6:0] s1_count_ff, s1_count_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic       req_accept;
   logic       s1_advance;
   logic       is_frame;
   logic [7:0] rem_eff;
   logic       take_lit;
   logic       take_trans;
   logic [7:0] run_len;

   pal_wr_type pal_wr;
   pal_rd_type pal_rd;
   logic [23:0] pal_rgb;

   // pipeline flow
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_valid && req_ready;

   // decode of the incoming byte
   assign is_frame   = (req_data.operation == OP_FRAME_DATA);
   assign rem_eff    = req_data.frame_start ? 8'd0 : lit_rem_ff;
   assign take_lit   = is_frame && (rem_eff != 8'd0);
   assign take_trans = is_frame && (rem_eff == 8'd0) && (req_data.data_byte > CTRL_RUN_BASE);
   assign run_len    = req_data.data_byte - CTRL_RUN_BASE;

   always_comb begin
      lit_rem_in = lit_rem_ff;
      if (req_accept && is_frame) begin
         if (take_lit) begin
            lit_rem_in = rem_eff - 8'd1;
         end else if (take_trans) begin
            lit_rem_in = 8'd0;
         end else begin
            // control byte 0x80 and below loads the literal count
            lit_rem_in = req_data.data_byte;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_trans_in = s1_trans_ff;
      s1_count_in = s1_count_ff;
      if (req_accept) begin
         s1_valid_in = take_lit || take_trans;
         s1_trans_in = take_trans;
         s1_count_in = take_trans ? run_len[6:0] : 7'd1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // palette port
   assign pal_wr.valid = req_accept && (req_data.operation == OP_PALETTE_WRITE);
   assign pal_wr.index = req_data.entry_index;
   assign pal_wr.rgb   = {req_data.entry_red, req_data.entry_green, req_data.entry_blue};
   assign pal_rd.valid = req_accept && take_lit;
   assign pal_rd.index = req_data.data_byte;

   prsd_palette u_palette (
      .clock  (clock),
      .wr     (pal_wr),
      .rd     (pal_rd),
      .rd_rgb (pal_rgb)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         if (s1_trans_ff) begin
            rsp_in.pixel_red   = TRANSPARENT_LEVEL;
            rsp_in.pixel_green = TRANSPARENT_LEVEL;
            rsp_in.pixel_blue  = TRANSPARENT_LEVEL;
         end else begin
            rsp_in.pixel_red   = pal_rgb[23:16];
            rsp_in.pixel_green = pal_rgb[15:8];
            rsp_in.pixel_blue  = pal_rgb[7:0];
         end
         rsp_in.repeat_count   = s1_count_ff;
         rsp_in.is_transparent = s1_trans_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_rem_ff   <= 8'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lit_rem_ff   <= lit_rem_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_trans_ff <= s1_trans_in;
      s1_count_ff <= s1_count_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_trans_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_transparent |-> rsp_ff.repeat_count != 7'd0)
      else $error("transparent run with zero length");

   a_literal_count_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_transparent |-> rsp_ff.repeat_count == 7'd1)
      else $error("literal pixel with repeat count other than one");

   a_literal_decrement: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_frame && !req_data.frame_start && (lit_rem_ff != 8'd0)
      |=> lit_rem_ff == $past(lit_rem_ff) - 8'd1)
      else $error("literal counter did not step down");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.operation == OP_PALETTE_WRITE) |=> !s1_valid_ff)
      else $error("palette write produced a pixel");
`endif

endmodule

`default_nettype wire

FILE: tb/palette_rle_sprite_decoder_core_tb.sv
// Self-checking testbench for the palette RLE sprite decoder core.
`timescale 1ns / 1ps

module palette_rle_sprite_decoder_core_tb;
   import prsd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
   localparam int RANDOM_UNTIL = 550;     // stop adding random words at this queue depth
   localparam int SHOWN_ERRORS = 10;

   // one queued input word, plus a flag that holds it back until the
   // decoder has returned every pixel still owed
   typedef struct packed {
      req_type word;
      logic    hold;
   } pending_word_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // stimulus
   pending_word_type word_queue [$];
   pending_word_type next_word;
   logic [7:0]  pal_written [$];        // palette entries safe to read
   logic        pal_seen [256];
   int          gen_left  = 0;          // literal bytes owed, as the stimulus sees it
   logic        hold_next = 1'b0;
   int          n_total   = 0;

   // decoder model
   logic [23:0] colour_model [PALETTE_DEPTH];
   logic [7:0]  lit_left = '0;
   rsp_type     pixel_expect [$];

   // bookkeeping
   int words_sent     = 0;
   int palette_writes = 0;
   int pixels_checked = 0;
   int runs_checked   = 0;
   int n_errors       = 0;
   int cycle_count    = 0;
   int idle_phase     = 0;              // 0: light sender gaps, 1: heavy, 2: none

   palette_rle_sprite_decoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder model: consumes one accepted word, queues the pixel it owes
   // ------------------------------------------------------------------
   function automatic void decode_word(req_type w);
      rsp_type     px;
      logic [23:0] rgb;
      px  = '0;
      rgb = '0;
      if (w.operation == OP_PALETTE_WRITE) begin
         // frame_start and data_byte are don't-care here; counter untouched
         if (int'(w.entry_index) < PALETTE_DEPTH)
            colour_model[w.entry_index] = {w.entry_red, w.entry_green, w.entry_blue};
      end else begin
         if (w.frame_start)
            lit_left = '0;
         if (lit_left != 0) begin
            // literal byte: palette lookup, one pixel
            lit_left = lit_left - 8'd1;
            if (int'(w.data_byte) < PALETTE_DEPTH)
               rgb = colour_model[w.data_byte];
            px.pixel_red      = rgb[23:16];
            px.pixel_green    = rgb[15:8];
            px.pixel_blue     = rgb[7:0];
            px.repeat_count   = 7'd1;
            px.is_transparent = 1'b0;
            pixel_expect.push_back(px);
         end else if (w.data_byte > CTRL_RUN_BASE) begin
            // transparent run, emitted as a single word
            px.pixel_red      = TRANSPARENT_LEVEL;
            px.pixel_green    = TRANSPARENT_LEVEL;
            px.pixel_blue     = TRANSPARENT_LEVEL;
            px.repeat_count   = 7'(w.data_byte - CTRL_RUN_BASE);
            px.is_transparent = 1'b1;
            pixel_expect.push_back(px);
         end else begin
            // 0x00 opens nothing, 0x80 opens 128 literals; no pixel either way
            lit_left = w.data_byte;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders; they track the literal count so that literal
   // bytes only ever point at palette entries already written
   // ------------------------------------------------------------------
   function automatic void add_palette(logic [7:0] idx, logic [23:0] rgb);
      pending_word_type p;
      p.word.operation   = OP_PALETTE_WRITE;
      p.word.data_byte   = 8'($urandom_range(0, 255));   // ignored by the block
      p.word.frame_start = 1'($urandom_range(0, 1));     // ignored by the block
      p.word.entry_index = idx;
      p.word.entry_red   = rgb[23:16];
      p.word.entry_green = rgb[15:8];
      p.word.entry_blue  = rgb[7:0];
      p.hold             = hold_next;
      hold_next          = 1'b0;
      word_queue.push_back(p);
      if (int'(idx) < PALETTE_DEPTH && !pal_seen[idx]) begin
         pal_seen[idx] = 1'b1;
         pal_written.push_back(idx);
      end
   endfunction

   function automatic void add_frame(logic [7:0] value, logic start);
      pending_word_type p;
      p.word.operation   = OP_FRAME_DATA;
      p.word.data_byte   = value;
      p.word.frame_start = start;
      p.word.entry_index = 8'($urandom_range(0, 255));
      p.word.entry_red   = 8'($urandom_range(0, 255));
      p.word.entry_green = 8'($urandom_range(0, 255));
      p.word.entry_blue  = 8'($urandom_range(0, 255));
      p.hold             = hold_next;
      hold_next          = 1'b0;
      word_queue.push_back(p);
      if (start)
         gen_left = 0;
      if (gen_left != 0)
         gen_left--;
      else if (value <= CTRL_RUN_BASE)
         gen_left = int'(value);
   endfunction

   function automatic logic [7:0] pick_index();
      return pal_written[$urandom_range(0, pal_written.size() - 1)];
   endfunction

   function automatic void note_error(string msg);
      n_errors++;
      if (n_errors <= SHOWN_ERRORS)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents queued words; valid stays up until accepted
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         idle_phase <= 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_word(req_data);
            if (req_data.operation == OP_PALETTE_WRITE)
               palette_writes++;
            words_sent++;
         end
         idle_phase <= (words_sent < n_total / 3)     ? 0 :
                       (words_sent < 2 * n_total / 3) ? 1 : 2;
         if (!req_valid || req_ready) begin
            if (word_queue.size() != 0
                && !(word_queue[0].hold && pixel_expect.size() != 0)
                && $urandom_range(0, 99) >= ((idle_phase == 0) ? 18 :
                                              (idle_phase == 1) ? 67 : 0)) begin
               next_word = word_queue.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_word.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random back-pressure, field-by-field pixel check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_expect.size() == 0) begin
               note_error($sformatf("stray pixel rgb=%02h%02h%02h cnt=%0d tr=%0b",
                  rsp_data.pixel_red, rsp_data.pixel_green, rsp_data.pixel_blue,
                  rsp_data.repeat_count, rsp_data.is_transparent));
            end else begin
               if (rsp_data.pixel_red      !== pixel_expect[0].pixel_red   ||
                   rsp_data.pixel_green    !== pixel_expect[0].pixel_green ||
                   rsp_data.pixel_blue     !== pixel_expect[0].pixel_blue  ||
                   rsp_data.repeat_count   !== pixel_expect[0].repeat_count ||
                   rsp_data.is_transparent !== pixel_expect[0].is_transparent)
                  note_error($sformatf({"pixel %0d: exp rgb=%02h%02h%02h cnt=%0d tr=%0b,",
                                        " got rgb=%02h%02h%02h cnt=%0d tr=%0b"},
                     pixels_checked,
                     pixel_expect[0].pixel_red, pixel_expect[0].pixel_green,
                     pixel_expect[0].pixel_blue, pixel_expect[0].repeat_count,
                     pixel_expect[0].is_transparent,
                     rsp_data.pixel_red, rsp_data.pixel_green, rsp_data.pixel_blue,
                     rsp_data.repeat_count, rsp_data.is_transparent));
               if (pixel_expect[0].is_transparent)
                  runs_checked++;
               void'(pixel_expect.pop_front());
            end
            pixels_checked++;
         end
         rsp_ready <= $urandom_range(0, 99) >= ((idle_phase == 0) ? 67 :
                                                 (idle_phase == 1) ? 18 : 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding",
                  cycle_count, pixel_expect.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: build the word list, release reset, drain, report
   // ------------------------------------------------------------------
   initial begin
      int   roll;
      logic start;

      foreach (pal_seen[i])
         pal_seen[i] = 1'b0;

      // directed: palette extremes first so every later literal is legal
      add_palette(8'h00, 24'h000000);
      add_palette(8'hFF, 24'hFFFFFF);
      add_palette(8'h5A, 24'h123456);
      add_palette(8'hA5, 24'hFEDCBA);
      add_frame(8'h81, 1'b1);             // shortest transparent run
      add_frame(8'hFF, 1'b0);             // longest transparent run
      add_frame(8'h00, 1'b0);             // empty literal group
      add_frame(8'h03, 1'b0);
      add_frame(8'h00, 1'b0);
      add_frame(8'hFF, 1'b0);
      add_frame(8'h5A, 1'b0);
      add_frame(8'h80, 1'b0);             // 0x80 opens 128 literals
      add_frame(8'hA5, 1'b0);
      add_palette(8'hA5, 24'h00FF00);     // write in mid-group leaves count alone
      add_frame(8'hA5, 1'b0);
      add_frame(8'h90, 1'b1);             // frame start cuts the group short
      add_frame(8'h02, 1'b0);
      add_frame(8'hFF, 1'b0);
      add_frame(8'h01, 1'b1);             // restart while a literal is owed
      add_frame(8'h00, 1'b0);

      // random: mostly well-formed frames, some aborted groups and stray writes
      hold_next = 1'b1;
      while (word_queue.size() < RANDOM_UNTIL) begin
         if (word_queue.size() == 200 || word_queue.size() == 400)
            hold_next = 1'b1;
         roll = $urandom_range(0, 99);
         if (gen_left != 0) begin
            if (roll < 88)
               add_frame(pick_index(), 1'b0);
            else if (roll < 94)
               add_palette(8'($urandom_range(0, 255)), 24'($urandom));
            else
               add_frame(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            start = ($urandom_range(0, 3) == 0);
            if (roll < 18)
               add_palette(8'($urandom_range(0, 255)), 24'($urandom));
            else if (roll < 50)
               add_frame(8'($urandom_range(129, 255)), start);
            else if (roll < 56)
               add_frame(8'h00, start);
            else if (roll < 59)
               add_frame(8'($urandom_range(9, 128)), start);   // long literal groups
            else
               add_frame(8'($urandom_range(1, 8)), start);
         end
      end
      n_total = word_queue.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (words_sent < n_total)
         @(posedge clock);
      while (pixel_expect.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);   // catch late extra pixels

      $display("%0d words sent (%0d palette writes); %0d pixels checked, %0d transparent runs",
               words_sent, palette_writes, pixels_checked, runs_checked);
      $display("%0d palette entries in use, %0d errors", pal_written.size(), n_errors);
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/prsd_pkg.sv
hw/rtl/prsd_palette.sv
hw/rtl/palette_rle_sprite_decoder_core.sv
tb/palette_rle_sprite_decoder_core_tb.sv
